// ===== rtl/core/mmed_pkg.sv =====
package mmed_pkg;

    localparam int POSITION_BITS_DEF = 48;
    localparam int FILE_LEN_W        = 48;
    localparam int LIMIT_W           = 24;
    localparam int CFG_DATA_W        = 48;
    localparam int CFG_INDEX_W       = 1;
    localparam int SUM_W             = 66;
    localparam int HDR_COUNT_W       = 3;

    localparam logic [31:0]          MOOV_TYPE    = 32'h6D6F_6F76;
    localparam logic [63:0]          HEADER_BYTES = 64'd8;
    localparam logic [63:0]          EXTENDED_MIN = 64'd16;
    localparam logic [31:0]          EXT_MARK     = 32'd1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = LIMIT_W'(128 * 1024);
    localparam logic [HDR_COUNT_W-1:0] HDR_LAST   = HDR_COUNT_W'(7);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILE_LENGTH  = 1'b0,
        REG_SEARCH_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        CAUSE_MOOV      = 3'd0,
        CAUSE_PAST      = 3'd1,
        CAUSE_OVERRUN   = 3'd2,
        CAUSE_BAD_SIZE  = 3'd3,
        CAUSE_FILE_END  = 3'd4
    } cause_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_EXT    = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [FILE_LEN_W-1:0] file_length;
        logic [LIMIT_W-1:0]    search_limit;
    } cfg_t;

    typedef struct packed {
        logic   valid;
        logic   streamable;
        cause_t cause;
    } verdict_t;

endpackage

// ===== rtl/core/mmed_cfg.sv =====
module mmed_cfg
    import mmed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [FILE_LEN_W-1:0] file_length_reg;
    logic [LIMIT_W-1:0]    search_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg  <= '0;
            search_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_FILE_LENGTH:  file_length_reg  <= cfg_data[FILE_LEN_W-1:0];
                REG_SEARCH_LIMIT: search_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          file_length_reg  <= file_length_reg;
            endcase
        end
    end

    assign cfg.file_length  = file_length_reg;
    assign cfg.search_limit = search_limit_reg;

endmodule

// ===== rtl/core/mmed_walker.sv =====
module mmed_walker
    import mmed_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output verdict_t   verdict
);

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] byte_position_reg, byte_position_next;
    logic [63:0]              header_shift_reg, header_shift_next;
    logic [HDR_COUNT_W-1:0]   header_count_reg, header_count_next;
    logic [POSITION_BITS-1:0] box_start_reg, box_start_next;
    logic [POSITION_BITS-1:0] prev_start_reg, prev_start_next;
    logic [POSITION_BITS-1:0] next_start_reg, next_start_next;
    logic                     decided_reg, decided_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [63:0]              shifted;
    logic [63:0]              box_len;
    logic [63:0]              min_len;
    logic [SUM_W-1:0]         box_end;
    logic [POSITION_BITS-1:0] box_end_pos;
    logic                     beyond_file;

    assign pos_inc     = byte_position_reg + POSITION_BITS'(1);
    assign shifted     = {header_shift_reg[55:0], data_byte};
    assign box_len     = (phase_reg == PH_EXT) ? shifted : {32'd0, shifted[63:32]};
    assign min_len     = (phase_reg == PH_EXT) ? EXTENDED_MIN : HEADER_BYTES;
    assign box_end     = SUM_W'(box_start_reg) + SUM_W'(box_len);
    assign box_end_pos = box_end[POSITION_BITS-1:0];
    assign beyond_file = SUM_W'(byte_position_reg) >= SUM_W'(cfg.file_length);

    always_comb
    begin
        phase_next         = phase_reg;
        byte_position_next = byte_position_reg;
        header_shift_next  = header_shift_reg;
        header_count_next  = header_count_reg;
        box_start_next     = box_start_reg;
        prev_start_next    = prev_start_reg;
        next_start_next    = next_start_reg;
        decided_next       = decided_reg;
        verdict            = '{valid: 1'b0, streamable: 1'b0, cause: CAUSE_MOOV};

        if (step && !decided_reg)
        begin
            if (beyond_file)
            begin
                verdict.valid = 1'b1;
                verdict.cause = CAUSE_FILE_END;
            end
            else if (phase_reg == PH_SKIP)
            begin
                if (pos_inc == next_start_reg)
                begin
                    box_start_next = next_start_reg;
                    phase_next     = PH_HEADER;
                end
            end
            else
            begin
                header_shift_next = shifted;
                if (header_count_reg != HDR_LAST)
                begin
                    header_count_next = header_count_reg + HDR_COUNT_W'(1);
                end
                else
                begin
                    header_count_next = '0;
                    if (phase_reg != PH_EXT &&
                        SUM_W'(prev_start_reg) >= SUM_W'(cfg.search_limit))
                    begin
                        verdict.valid = 1'b1;
                        verdict.cause = CAUSE_PAST;
                    end
                    else if (phase_reg != PH_EXT && shifted[31:0] == MOOV_TYPE)
                    begin
                        verdict.valid      = 1'b1;
                        verdict.streamable = 1'b1;
                        verdict.cause      = CAUSE_MOOV;
                    end
                    else if (phase_reg != PH_EXT && shifted[63:32] == EXT_MARK)
                    begin
                        phase_next = PH_EXT;
                    end
                    else if (box_len < min_len)
                    begin
                        verdict.valid = 1'b1;
                        verdict.cause = CAUSE_BAD_SIZE;
                    end
                    else if (box_end > SUM_W'(cfg.file_length))
                    begin
                        verdict.valid = 1'b1;
                        verdict.cause = CAUSE_OVERRUN;
                    end
                    else
                    begin
                        next_start_next = box_end_pos;
                        prev_start_next = box_start_reg;
                        if (box_end_pos == pos_inc)
                        begin
                            box_start_next = box_end_pos;
                            phase_next     = PH_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end

            if (!verdict.valid && last_byte)
            begin
                verdict.valid = 1'b1;
                verdict.cause = CAUSE_FILE_END;
            end
            byte_position_next = pos_inc;
            if (verdict.valid)
            begin
                decided_next = 1'b1;
            end
        end

        if (step && last_byte)
        begin
            phase_next         = PH_HEADER;
            byte_position_next = '0;
            header_shift_next  = '0;
            header_count_next  = '0;
            box_start_next     = '0;
            prev_start_next    = '0;
            next_start_next    = '0;
            decided_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            byte_position_reg <= '0;
            header_shift_reg  <= '0;
            header_count_reg  <= '0;
            box_start_reg     <= '0;
            prev_start_reg    <= '0;
            next_start_reg    <= '0;
            decided_reg       <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_position_reg <= byte_position_next;
            header_shift_reg  <= header_shift_next;
            header_count_reg  <= header_count_next;
            box_start_reg     <= box_start_next;
            prev_start_reg    <= prev_start_next;
            next_start_reg    <= next_start_next;
            decided_reg       <= decided_next;
        end
    end

`ifndef ASSERT_OFF
    a_single_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step && decided_reg |-> !verdict.valid)
        else $error("second verdict within one file");

    a_verdict_latches: assert property (@(posedge clk) disable iff (!rst_n)
        step && verdict.valid && !last_byte |=> decided_reg)
        else $error("verdict not recorded");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> byte_position_reg == '0 && !decided_reg
            && header_count_reg == '0)
        else $error("scan state not cleared after final byte");

    a_streamable_moov: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> verdict.streamable == (verdict.cause == CAUSE_MOOV))
        else $error("streamable flag disagrees with cause");
`endif

endmodule

// ===== rtl/core/mp4_moov_early_detector.sv =====
// A word taken on the input is held in the input register; as it advances, any verdict
// it gives is registered in the result register, which drives the output. One word per
// cycle unless a verdict waits for m_tready, when one new word can still be taken in.
// Reset: rst_n clears scan state and both stages; file_length resets to 0 and
// search_limit to 131072. Scan state also clears after each word with tlast set.
module mp4_moov_early_detector
    import mmed_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata    // [0] streamable, [3:1] cause, [7:4] zero
);

    cfg_t     cfg;
    verdict_t verdict;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_stream_reg;
    cause_t     out_cause_reg;
    logic       advance;

    mmed_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mmed_walker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .verdict   (verdict)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= verdict.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_stream_reg <= verdict.streamable;
            out_cause_reg  <= verdict.cause;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_cause_reg, out_stream_reg};

endmodule
